// ===== rtl/core/multi_priority_message_queue_macros.svh =====
// assertion macros for the message queue
`ifndef MULTI_PRIORITY_MESSAGE_QUEUE_MACROS_SVH
`define MULTI_PRIORITY_MESSAGE_QUEUE_MACROS_SVH
// property holds every cycle outside reset
`define MPMQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// implication checked from the next cycle
`define MPMQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/core/mpmq_pkg.sv =====
// shared types and codes for the message queue
package mpmq_pkg;
   localparam logic [1:0] FUNC_PUSH = 2'd0;
   localparam logic [1:0] FUNC_POP_TOP = 2'd1;
   localparam logic [1:0] FUNC_POP_KEY = 2'd2;
   localparam logic [1:0] FUNC_POP_PRIO = 2'd3;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_BADPRIO = 2'd3;
   localparam int KEY_W = 64;
   localparam int HANDLE_W = 16;
   localparam int PRIO_W = 2;
   localparam int LEVELS_W = 3;

   // controller to datapath
   typedef struct packed {
      logic search;
      logic commit;
   } ctrl_type;
endpackage

// ===== rtl/core/mpmq_datapath.sv =====
// slot store with parallel search, close-up shift and result registers
module mpmq_datapath #(
   parameter int MAX_LEVELS = 4,
   parameter int STORE_DEPTH = 16,
   localparam int CNT_W = $clog2(STORE_DEPTH + 1),
   localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
   input  logic clock,
   input  logic reset,
   input  mpmq_pkg::ctrl_type ctrl,
   input  logic [2:0] levels_cfg,
   input  logic [1:0] func,
   input  logic [1:0] prio,
   input  logic [63:0] key,
   input  logic [15:0] handle,
   output logic [1:0] status,
   output logic [15:0] out_handle,
   output logic [63:0] out_key,
   output logic [1:0] out_prio,
   output logic [CNT_W-1:0] queued_count
);
   import mpmq_pkg::*;

   logic [KEY_W-1:0] key_ff [STORE_DEPTH];
   logic [HANDLE_W-1:0] hdl_ff [STORE_DEPTH];
   logic [PRIO_W-1:0] lvl_ff [STORE_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;

   // search stage results
   logic [MAX_LEVELS-1:0] lvl_hit_in, lvl_hit_ff, key_hit_in, key_hit_ff;
   logic [IDX_W-1:0] lvl_pos_in [MAX_LEVELS];
   logic [IDX_W-1:0] key_pos_in [MAX_LEVELS];
   logic [IDX_W-1:0] lvl_pos_ff [MAX_LEVELS];
   logic [IDX_W-1:0] key_pos_ff [MAX_LEVELS];
   logic [2:0] levels;

   logic [1:0] status_ff, status_in;
   logic [15:0] ohdl_ff, ohdl_in;
   logic [63:0] okey_ff, okey_in;
   logic [1:0] oprio_ff, oprio_in;

   always_comb begin
      levels = levels_cfg;
      if (levels == 3'd0) levels = 3'd1;
      if (32'(levels) > MAX_LEVELS) levels = 3'(MAX_LEVELS);
   end

   // per-level first match, slots scanned in parallel
   always_comb begin
      for (int l = 0; l < MAX_LEVELS; l++) begin
         lvl_hit_in[l] = 1'b0;
         key_hit_in[l] = 1'b0;
         lvl_pos_in[l] = '0;
         key_pos_in[l] = '0;
         for (int i = STORE_DEPTH - 1; i >= 0; i--) begin
            if (CNT_W'(i) < count_ff && 32'(lvl_ff[i]) == l) begin
               lvl_hit_in[l] = 1'b1;
               lvl_pos_in[l] = IDX_W'(i);
               if (key_ff[i] == key) begin
                  key_hit_in[l] = 1'b1;
                  key_pos_in[l] = IDX_W'(i);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.search) begin
         lvl_hit_ff <= lvl_hit_in;
         key_hit_ff <= key_hit_in;
         lvl_pos_ff <= lvl_pos_in;
         key_pos_ff <= key_pos_in;
      end
   end

   logic take;
   logic [IDX_W-1:0] pos;
   logic push_ok;
   logic [1:0] push_lvl;

   always_comb begin
      take = 1'b0;
      pos = '0;
      push_ok = 1'b0;
      push_lvl = (levels > 3'd1) ? prio : 2'd0;
      status_in = ST_EMPTY;
      unique case (func)
         FUNC_PUSH: begin
            if (32'(count_ff) >= STORE_DEPTH) status_in = ST_FULL;
            else if ({1'b0, push_lvl} >= levels) status_in = ST_BADPRIO;
            else begin
               status_in = ST_OK;
               push_ok = 1'b1;
            end
         end
         FUNC_POP_TOP: begin
            for (int l = MAX_LEVELS - 1; l >= 0; l--) begin
               if (l < 32'(levels) && lvl_hit_ff[l]) begin
                  take = 1'b1;
                  pos = lvl_pos_ff[l];
               end
            end
         end
         FUNC_POP_KEY: begin
            for (int l = MAX_LEVELS - 1; l >= 0; l--) begin
               if (l < 32'(levels) && key_hit_ff[l]) begin
                  take = 1'b1;
                  pos = key_pos_ff[l];
               end
            end
         end
         default: begin
            if (levels <= 3'd1 || {1'b0, prio} >= levels) status_in = ST_BADPRIO;
            else begin
               for (int l = 0; l < MAX_LEVELS; l++) begin
                  if (32'(prio) == l && lvl_hit_ff[l]) begin
                     take = 1'b1;
                     pos = lvl_pos_ff[l];
                  end
               end
            end
         end
      endcase
      if (take) status_in = ST_OK;
      ohdl_in = take ? hdl_ff[pos] : '0;
      okey_in = take ? key_ff[pos] : '0;
      oprio_in = take ? lvl_ff[pos] : '0;
      count_in = count_ff;
      if (push_ok) count_in = count_ff + 1'b1;
      else if (take) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.commit) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         status_ff <= status_in;
         ohdl_ff <= ohdl_in;
         okey_ff <= okey_in;
         oprio_ff <= oprio_in;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            if (push_ok && CNT_W'(i) == count_ff) begin
               key_ff[i] <= key;
               hdl_ff[i] <= handle;
               lvl_ff[i] <= push_lvl;
            end else if (take && i < STORE_DEPTH - 1 && IDX_W'(i) >= pos) begin
               // close the gap left by the removed slot
               key_ff[i] <= key_ff[(i + 1) % STORE_DEPTH];
               hdl_ff[i] <= hdl_ff[(i + 1) % STORE_DEPTH];
               lvl_ff[i] <= lvl_ff[(i + 1) % STORE_DEPTH];
            end
         end
      end
   end

   assign status = status_ff;
   assign out_handle = ohdl_ff;
   assign out_key = okey_ff;
   assign out_prio = oprio_ff;
   assign queued_count = count_ff;
endmodule

// ===== rtl/core/mpmq_ctrl.sv =====
// request sequencer: search, commit, respond
module mpmq_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   output logic done,
   output mpmq_pkg::ctrl_type ctrl
);
   import mpmq_pkg::*;

   typedef enum logic [1:0] {IDLE, SEARCH, COMMIT} state_type;
   state_type state_ff;
   logic done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            IDLE: if (start) state_ff <= SEARCH;
            SEARCH: state_ff <= COMMIT;
            COMMIT: begin
               state_ff <= IDLE;
               done_ff <= 1'b1;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign busy = (state_ff != IDLE);
   assign done = done_ff;
   assign ctrl.search = (state_ff == SEARCH);
   assign ctrl.commit = (state_ff == COMMIT);
endmodule

// ===== rtl/core/multi_priority_message_queue.sv =====
// top level of the strict-priority message queue
// A request is taken when start is high and busy is low; its single result
// appears on the rsp_ ports, with rsp_valid high for one cycle, after the
// SEARCH and COMMIT states, and a new request can be taken in that same cycle.
// Each request passes through the parallel slot search and the commit that
// shifts the store, and busy holds off a new request until it is through.
// The receiver cannot stall: rsp_ data holds only until the next request's commit.
module multi_priority_message_queue #(
   parameter int MAX_LEVELS = 4,
   parameter int STORE_DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_func,
   input  logic [1:0] req_prio,
   input  logic [63:0] req_key,
   input  logic [15:0] req_handle,
   output logic rsp_valid,
   output logic [1:0] rsp_status,
   output logic [15:0] rsp_out_handle,
   output logic [63:0] rsp_out_key,
   output logic [1:0] rsp_out_prio,
   output logic [$clog2(STORE_DEPTH+1)-1:0] rsp_queued_count,
   input  logic csr_we,
   input  logic [2:0] csr_wdata
);
   import mpmq_pkg::*;
`include "multi_priority_message_queue_macros.svh"

   ctrl_type ctrl;
   logic [2:0] levels_ff;
   logic [1:0] func_ff, prio_ff;
   logic [63:0] key_ff;
   logic [15:0] handle_ff;

   always_ff @(posedge clock) begin
      if (reset) levels_ff <= 3'd3;
      else if (csr_we) levels_ff <= csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         func_ff <= req_func;
         prio_ff <= req_prio;
         key_ff <= req_key;
         handle_ff <= req_handle;
      end
   end

   mpmq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .done(rsp_valid), .ctrl(ctrl)
   );

   mpmq_datapath #(.MAX_LEVELS(MAX_LEVELS), .STORE_DEPTH(STORE_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .levels_cfg(levels_ff),
      .func(func_ff), .prio(prio_ff), .key(key_ff), .handle(handle_ff),
      .status(rsp_status), .out_handle(rsp_out_handle), .out_key(rsp_out_key),
      .out_prio(rsp_out_prio), .queued_count(rsp_queued_count)
   );

   `MPMQ_ASSERT(a_count_range, 32'(rsp_queued_count) <= STORE_DEPTH, "count past depth")
   `MPMQ_ASSERT_NEXT(a_done_after_commit, ctrl.commit, rsp_valid, "missing result")
   `MPMQ_ASSERT(a_one_phase, !(ctrl.search && ctrl.commit), "phases overlap")
   `MPMQ_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request not taken")
endmodule
